// ----- rtl/parallel_led_bitplane_encoder_core_macros.svh -----
// assertion macros shared by the encoder core
`ifndef PARALLEL_LED_BITPLANE_ENCODER_CORE_MACROS_SVH
`define PARALLEL_LED_BITPLANE_ENCODER_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define PLBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define PLBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/plbe_pkg.sv -----
// types, constants and helpers of the led bitplane encoder
package plbe_pkg;

	// fixed field widths
	localparam int KIND_W     = 2;
	localparam int CH_FIELD_W = 3;
	localparam int PIX_W      = 9;
	localparam int COLOR_BITS = 24;
	localparam int ALPHA_W    = 8;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 10;
	localparam int POS_W      = 16;
	localparam int FRAME_W    = 17;
	localparam int QUEUE_DEPTH = 2;

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMIT  = 2'd2;

	// 72 bytes per pixel, as 64 + 8
	localparam int BPP_SHIFT_HI = 6;
	localparam int BPP_SHIFT_LO = 3;

	// reciprocals for divide by 9 (16-bit shift) and by 3 (9-bit shift)
	localparam logic [12:0] DIV9_MUL   = 13'd7282;
	localparam int          DIV9_SHIFT = 16;
	localparam logic [7:0]  DIV3_MUL   = 8'd171;
	localparam int          DIV3_SHIFT = 9;

	// pulse phases within one colour bit
	localparam logic [1:0] PHASE_HIGH = 2'd0;
	localparam logic [1:0] PHASE_DATA = 2'd1;

	localparam logic [BYTE_W-1:0]  PULSE_HIGH = 8'hff;
	localparam logic [BYTE_W-1:0]  PULSE_LOW  = 8'h00;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;

	typedef enum logic [1:0] {
		OP_SET,
		OP_CLEAR,
		OP_EMIT
	} op_kind_t;

	// one classified command in the queue
	typedef struct packed {
		op_kind_t                kind;
		logic [CH_FIELD_W-1:0]   channel;
		logic [PIX_W-1:0]        pixel;
		logic [COLOR_BITS-1:0]   color;
		logic [ALPHA_W-1:0]      alpha;
	} op_t;

	// frame geometry derived from the pixel count
	typedef struct packed {
		logic [FRAME_W-1:0] frame_len;
		logic [FRAME_W-1:0] body_end;
	} frame_cfg_t;

	// exact floor(x / 255) for 16-bit x up to 255 * 255
	function automatic logic [BYTE_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ----- rtl/plbe_ifs.sv -----
// valid/ready channels of the encoder: command input and frame output
interface plbe_cmd_if import plbe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     kind;
	logic [CH_FIELD_W-1:0] channel;
	logic [PIX_W-1:0]      pixel;
	logic [COLOR_BITS-1:0] color;
	logic [ALPHA_W-1:0]    alpha;

	modport source(output valid, kind, channel, pixel, color, alpha, input ready);
	modport sink(input valid, kind, channel, pixel, color, alpha, output ready);
endinterface

interface plbe_frame_if import plbe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tx_byte;
	logic              last;

	modport source(output valid, tx_byte, last, input ready);
	modport sink(input valid, tx_byte, last, output ready);
endinterface

// ----- rtl/plbe_ram.sv -----
// generic single-write, single-read ram with registered read data
module plbe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/plbe_front.sv -----
// command front end: pixel count register, frame geometry, classification
module plbe_front import plbe_pkg::*; #(
	parameter int CHANNELS         = 8,
	parameter int MAX_PIXELS       = 512,
	parameter int LEAD_ZERO_BYTES  = 4,
	parameter int TRAIL_ZERO_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	plbe_cmd_if.sink         cmd,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             init_done,
	input  logic             q_full,
	output logic             push,
	output op_t              push_op,
	output frame_cfg_t       frame_cfg
);
	localparam int NPIX_W = $clog2(MAX_PIXELS + 1);
	localparam int NW     = (NPIX_W > CNT_W) ? NPIX_W : CNT_W;

	logic [CNT_W-1:0] pixel_count_q;
	frame_cfg_t       frame_cfg_q;
	logic [NW-1:0]    npix;
	logic             keep;
	logic             ch_ok;
	logic             pix_ok;

	// count in use, limited to the store size
	function automatic logic [NW-1:0] clip_count(input logic [CNT_W-1:0] c);
		logic [NW-1:0] w;
		w = NW'(c);
		if (w > NW'(MAX_PIXELS)) begin
			w = NW'(MAX_PIXELS);
		end
		return w;
	endfunction

	// frame geometry for a pixel count
	function automatic frame_cfg_t calc_cfg(input logic [CNT_W-1:0] c);
		logic [NW-1:0]      n;
		logic [FRAME_W-1:0] body;
		frame_cfg_t         r;
		n = clip_count(c);
		body = (FRAME_W'(n) << BPP_SHIFT_HI) + (FRAME_W'(n) << BPP_SHIFT_LO);
		r.body_end  = FRAME_W'(LEAD_ZERO_BYTES) + body;
		r.frame_len = r.body_end + FRAME_W'(TRAIL_ZERO_BYTES);
		return r;
	endfunction

	// configuration register and derived geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
			frame_cfg_q   <= calc_cfg('0);
		end else if (cfg_we) begin
			pixel_count_q <= cfg_wdata;
			frame_cfg_q   <= calc_cfg(cfg_wdata);
		end
	end

	assign npix      = clip_count(pixel_count_q);
	assign frame_cfg = frame_cfg_q;

	// take beats once the store is cleared and the queue has room
	assign cmd.ready = init_done && !q_full;

	// range checks of a set command
	assign ch_ok  = 4'(cmd.channel) < 4'(CHANNELS);
	assign pix_ok = NW'(cmd.pixel) < npix;

	// classify; dropped commands are taken but not queued
	always_comb begin
		push_op.channel = cmd.channel;
		push_op.pixel   = cmd.pixel;
		push_op.color   = cmd.color;
		push_op.alpha   = cmd.alpha;
		case (cmd.kind)
			KIND_SET: begin
				push_op.kind = OP_SET;
				keep = ch_ok && pix_ok;
			end
			KIND_CLEAR: begin
				push_op.kind = OP_CLEAR;
				keep = 1'b1;
			end
			KIND_EMIT: begin
				push_op.kind = OP_EMIT;
				keep = 1'b1;
			end
			default: begin
				push_op.kind = OP_EMIT;
				keep = 1'b0;
			end
		endcase
	end

	assign push = cmd.valid && cmd.ready && keep;
endmodule

// ----- rtl/plbe_queue.sv -----
// short command queue between front end and back end
module plbe_queue import plbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head,
	output logic empty
);
	localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	op_t            slot_q [QUEUE_DEPTH];
	logic [QW-1:0]  wr_ptr_q;
	logic [QW-1:0]  rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = count_q == QCW'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end
endmodule

// ----- rtl/plbe_back.sv -----
// back end: colour store, blend, clearing sweep and frame byte generation
module plbe_back import plbe_pkg::*; #(
	parameter int CHANNELS        = 8,
	parameter int MAX_PIXELS      = 512,
	parameter int LEAD_ZERO_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  op_t        head,
	output logic       pop,
	input  frame_cfg_t frame_cfg,
	output logic       init_done,
	plbe_frame_if.source frame
);
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SET_MUL,
		ST_SET_WR,
		ST_EM_ADDR,
		ST_EM_OUT
	} state_t;

	state_t            state_q;
	logic              init_done_q;
	logic [AW-1:0]     sweep_cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] tx_byte_q;
	logic              last_q;

	op_t               op_q;
	logic [AW-1:0]     raddr_q;
	logic              zero_s1;
	logic              last_s1;
	logic [POS_W-1:0]  off_s1;
	logic [25:0]       prod_s1;
	logic              zero_s2;
	logic              last_s2;
	logic [6:0]        rem_s2;
	logic [14:0]       bitp_s2;
	logic [15:0]       mul_old_s1 [3];
	logic [15:0]       mul_new_s1 [3];

	logic [COLOR_BITS-1:0] rdata [CHANNELS];
	logic                  lane_we [CHANNELS];
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [COLOR_BITS-1:0] wdata;

	logic [FRAME_W-1:0]    pos_sel;
	logic [FRAME_W-1:0]    pos_nxt;
	logic [FRAME_W-1:0]    lead_ext;
	logic                  em_last;
	logic                  in_body;
	logic [POS_W-1:0]      off;
	logic [25:0]           prod;
	logic [9:0]            pix_full;
	logic [POS_W-1:0]      pix_bytes;
	logic [POS_W-1:0]      rem_full;
	logic [14:0]           bitp;
	logic [4:0]            bit_idx;
	logic [6:0]            bit_x3;
	logic [1:0]            phase;
	logic [BYTE_W-1:0]     plane;
	logic [BYTE_W-1:0]     em_byte;
	logic [COLOR_BITS-1:0] old_color;
	logic [COLOR_BITS-1:0] blend;
	logic [COLOR_BITS-1:0] new_color;
	logic [15:0]           mul_old [3];
	logic [15:0]           mul_new [3];
	logic                  out_load;

	// one ram lane per channel, all at the same pixel address
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		plbe_ram #(
			.WIDTH(COLOR_BITS),
			.DEPTH(MAX_PIXELS)
		) u_ram (
			.clk  (clk),
			.we   (lane_we[g]),
			.waddr(waddr),
			.wdata(wdata),
			.raddr(raddr),
			.rdata(rdata[g])
		);
	end

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign init_done = init_done_q;

	// frame position: wrap if past the end, find region and offset
	assign lead_ext = FRAME_W'(LEAD_ZERO_BYTES);
	assign pos_sel  = ({1'b0, pos_q} >= frame_cfg.frame_len) ? '0 : {1'b0, pos_q};
	assign pos_nxt  = pos_sel + 1'b1;
	assign em_last  = pos_nxt >= frame_cfg.frame_len;
	assign in_body  = (pos_sel >= lead_ext) && (pos_sel < frame_cfg.body_end);
	assign off      = POS_W'(pos_sel - lead_ext);
	// pixel = (off / 8) / 9 by reciprocal
	assign prod     = 26'(off[15:3]) * 26'(DIV9_MUL);

	// remainder within the pixel, then colour bit by reciprocal of 3
	assign pix_full  = prod_s1[DIV9_SHIFT +: 10];
	assign pix_bytes = (POS_W'(pix_full) << BPP_SHIFT_HI) + (POS_W'(pix_full) << BPP_SHIFT_LO);
	assign rem_full  = off_s1 - pix_bytes;
	assign bitp      = 15'(rem_full[6:0]) * 15'(DIV3_MUL);

	// assemble the frame byte from the held ram row
	assign bit_idx = bitp_s2[DIV3_SHIFT +: 5];
	assign bit_x3  = {1'b0, bit_idx, 1'b0} + {2'b00, bit_idx};
	assign phase   = 2'(rem_s2 - bit_x3);

	always_comb begin
		plane = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			plane[c] = rdata[c][5'(COLOR_BITS - 1) - bit_idx];
		end
		if (zero_s2) begin
			em_byte = PULSE_LOW;
		end else if (phase == PHASE_HIGH) begin
			em_byte = PULSE_HIGH;
		end else if (phase == PHASE_DATA) begin
			em_byte = plane;
		end else begin
			em_byte = PULSE_LOW;
		end
	end

	// blend: select the addressed lane, form byte products
	always_comb begin
		old_color = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (op_q.channel == CH_FIELD_W'(c)) begin
				old_color = old_color | rdata[c];
			end
		end
		for (int k = 0; k < 3; k++) begin
			mul_old[k] = 16'(old_color[8*k +: 8]) * 16'(ALPHA_FULL - op_q.alpha);
			mul_new[k] = 16'(op_q.color[8*k +: 8]) * 16'(op_q.alpha);
		end
	end

	// blend: scale each product by 1/255 and sum
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			blend[8*k +: 8] = div255(mul_old_s1[k]) + div255(mul_new_s1[k]);
		end
		new_color = (op_q.alpha == ALPHA_FULL) ? op_q.color : blend;
	end

	// ram read address: live on the issuing cycle, held afterwards
	always_comb begin
		case (state_q)
			ST_IDLE:    raddr = AW'(head.pixel);
			ST_EM_ADDR: raddr = AW'(pix_full);
			default:    raddr = raddr_q;
		endcase
	end

	// ram write: whole rows during a sweep, one lane on a set
	always_comb begin
		waddr = sweep_cnt_q;
		wdata = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			lane_we[c] = 1'b0;
		end
		case (state_q)
			ST_SWEEP: begin
				for (int c = 0; c < CHANNELS; c++) begin
					lane_we[c] = 1'b1;
				end
			end
			ST_SET_WR: begin
				waddr = AW'(op_q.pixel);
				wdata = new_color;
				for (int c = 0; c < CHANNELS; c++) begin
					lane_we[c] = op_q.channel == CH_FIELD_W'(c);
				end
			end
			default: begin
				waddr = sweep_cnt_q;
			end
		endcase
	end

	assign out_load = (state_q == ST_EM_OUT) && (!out_valid_q || frame.ready);

	// sequencer, frame position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			init_done_q <= 1'b0;
			sweep_cnt_q <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			tx_byte_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				tx_byte_q   <= em_byte;
				last_q      <= last_s2;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_cnt_q == AW'(MAX_PIXELS - 1)) begin
						sweep_cnt_q <= '0;
						init_done_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						case (head.kind)
							OP_SET:   state_q <= ST_SET_MUL;
							OP_CLEAR: state_q <= ST_SWEEP;
							OP_EMIT: begin
								pos_q   <= em_last ? '0 : pos_nxt[POS_W-1:0];
								state_q <= ST_EM_ADDR;
							end
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SET_MUL: state_q <= ST_SET_WR;
				ST_SET_WR:  state_q <= ST_IDLE;
				ST_EM_ADDR: state_q <= ST_EM_OUT;
				ST_EM_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath pipeline registers
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q    <= head;
			raddr_q <= raddr;
			zero_s1 <= !in_body;
			last_s1 <= em_last;
			off_s1  <= off;
			prod_s1 <= prod;
		end
		if (state_q == ST_EM_ADDR) begin
			raddr_q <= raddr;
			zero_s2 <= zero_s1;
			last_s2 <= last_s1;
			rem_s2  <= rem_full[6:0];
			bitp_s2 <= bitp;
		end
		if (state_q == ST_SET_MUL) begin
			for (int k = 0; k < 3; k++) begin
				mul_old_s1[k] <= mul_old[k];
				mul_new_s1[k] <= mul_new[k];
			end
		end
	end

	assign frame.valid   = out_valid_q;
	assign frame.tx_byte = tx_byte_q;
	assign frame.last    = last_q;
endmodule

// ----- rtl/parallel_led_bitplane_encoder_core.sv -----
// channel   dir  beat contents
// cmd       in   kind, channel, pixel, color, alpha
// frame     out  tx_byte, last
// cfg       in   pixel_count write (cfg_we, cfg_wdata)
//
// set commands pass through ST_SET_MUL and ST_SET_WR in the back end, emits through ST_EM_ADDR
// and ST_EM_OUT; clear sweeps the whole store, one store row per cycle.
// after reset a sweep zeroes the store; cmd.ready stays low until then.
// a two-entry queue parts intake from execution; a stalled frame output holds its byte,
// the next emit then waits in the back end and up to two commands queue behind it.
`include "parallel_led_bitplane_encoder_core_macros.svh"

module parallel_led_bitplane_encoder_core import plbe_pkg::*; #(
	parameter int CHANNELS         = 8,
	parameter int MAX_PIXELS       = 512,
	parameter int LEAD_ZERO_BYTES  = 4,
	parameter int TRAIL_ZERO_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	plbe_cmd_if.sink         cmd,
	plbe_frame_if.source     frame,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);
	logic       q_push;
	op_t        q_push_op;
	logic       q_full;
	logic       q_pop;
	op_t        q_head;
	logic       q_empty;
	logic       init_done;
	frame_cfg_t frame_cfg;

	// intake and classification
	plbe_front #(
		.CHANNELS        (CHANNELS),
		.MAX_PIXELS      (MAX_PIXELS),
		.LEAD_ZERO_BYTES (LEAD_ZERO_BYTES),
		.TRAIL_ZERO_BYTES(TRAIL_ZERO_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.init_done(init_done),
		.q_full   (q_full),
		.push     (q_push),
		.push_op  (q_push_op),
		.frame_cfg(frame_cfg)
	);

	// command queue
	plbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(q_push_op),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	// execution
	plbe_back #(
		.CHANNELS       (CHANNELS),
		.MAX_PIXELS     (MAX_PIXELS),
		.LEAD_ZERO_BYTES(LEAD_ZERO_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (q_head),
		.pop      (q_pop),
		.frame_cfg(frame_cfg),
		.init_done(init_done),
		.frame    (frame)
	);

	// queue discipline and start-up sweep
	`PLBE_ASSERT_IMP(a_no_push_full, clk, arst_n, q_push, !q_full, "queue push while full")
	`PLBE_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, !q_empty, "queue pop while empty")
	`PLBE_ASSERT_NXT(a_init_holds, clk, arst_n, init_done, init_done, "init done dropped")
	`PLBE_ASSERT_IMP(a_ready_needs_init, clk, arst_n, cmd.ready, init_done, "ready before sweep")
endmodule

// ----- sim/tb_parallel_led_bitplane_encoder_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the parallel led bitplane encoder core
module tb_parallel_led_bitplane_encoder_core;
	import plbe_pkg::*;

	localparam int CHANNELS         = 8;
	localparam int MAX_PIXELS       = 512;
	localparam int LEAD_ZERO_BYTES  = 4;
	localparam int TRAIL_ZERO_BYTES = 4;
	localparam int BYTES_PER_PIXEL  = 72;
	localparam int PULSES_PER_BIT   = 3;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// a clear walks the whole store, and up to three can be queued or running
	localparam int SETTLE_CYCLES  = 4 * (MAX_PIXELS + 1) + 16;
	localparam int DRAIN_CYCLES   = 64;
	localparam int RAND_PER_PHASE = 80;
	localparam int DIR_N          = 26;
	localparam int PHASES         = 8;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [CH_FIELD_W-1:0] channel;
		logic [PIX_W-1:0]      pixel;
		logic [COLOR_BITS-1:0] color;
		logic [ALPHA_W-1:0]    alpha;
	} cmd_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              last;
	} frame_beat_t;

	// one directed row; typed rows carry their own frame byte
	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [CH_FIELD_W-1:0] channel;
		logic [PIX_W-1:0]      pixel;
		logic [COLOR_BITS-1:0] color;
		logic [ALPHA_W-1:0]    alpha;
		logic                  typed;
		logic [BYTE_W-1:0]     tx_byte;
		logic                  last;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	plbe_cmd_if   cmd_ch();
	plbe_frame_if frame_ch();

	parallel_led_bitplane_encoder_core #(
		.CHANNELS        (CHANNELS),
		.MAX_PIXELS      (MAX_PIXELS),
		.LEAD_ZERO_BYTES (LEAD_ZERO_BYTES),
		.TRAIL_ZERO_BYTES(TRAIL_ZERO_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.frame    (frame_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predicted state of the encoder
	logic [COLOR_BITS-1:0] color_mem [CHANNELS][MAX_PIXELS];
	int unsigned           frame_pos;
	logic [CNT_W-1:0]      pixel_count_reg;

	frame_beat_t pending_frame_bytes[$];
	dir_row_t    dir_rows [DIR_N];

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int n_sets;
	int n_clears;
	int n_emits;
	int n_spare;
	int n_settings;
	int bytes_checked;
	int lasts_seen;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout at %0t, %0d frame bytes still outstanding", $time,
			pending_frame_bytes.size());
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned pixels_in_use();
		return (pixel_count_reg > MAX_PIXELS) ? MAX_PIXELS : int'(pixel_count_reg);
	endfunction

	function automatic void clear_colors();
		for (int c = 0; c < CHANNELS; c++)
			for (int p = 0; p < MAX_PIXELS; p++)
				color_mem[c][p] = '0;
	endfunction

	// per-byte blend, each quotient truncated on its own
	function automatic logic [COLOR_BITS-1:0] blend_color(input logic [COLOR_BITS-1:0] old_c,
		input logic [COLOR_BITS-1:0] new_c, input logic [ALPHA_W-1:0] a);
		logic [COLOR_BITS-1:0] res;
		int unsigned           o;
		int unsigned           n;
		int unsigned           w;
		w = a;
		for (int k = 0; k < 3; k++) begin
			o = old_c[8*k +: 8];
			n = new_c[8*k +: 8];
			res[8*k +: 8] = 8'((o * (255 - w)) / 255 + (n * w) / 255);
		end
		return res;
	endfunction

	// frame byte at a position: lead zeros, three pulses per colour bit, trail zeros
	function automatic logic [BYTE_W-1:0] bitplane_byte(input int unsigned pos,
		input int unsigned npix);
		int unsigned       off;
		int unsigned       pix;
		int unsigned       rem;
		int unsigned       bit_idx;
		int unsigned       phase;
		logic [BYTE_W-1:0] b;
		b = PULSE_LOW;
		if (pos < LEAD_ZERO_BYTES)
			return PULSE_LOW;
		off = pos - LEAD_ZERO_BYTES;
		if (off >= npix * BYTES_PER_PIXEL)
			return PULSE_LOW;
		pix = off / BYTES_PER_PIXEL;
		rem = off % BYTES_PER_PIXEL;
		bit_idx = rem / PULSES_PER_BIT;
		phase = rem % PULSES_PER_BIT;
		if (phase == PHASE_HIGH)
			return PULSE_HIGH;
		if (phase != PHASE_DATA)
			return PULSE_LOW;
		for (int c = 0; c < CHANNELS; c++)
			b[c] = color_mem[c][pix][COLOR_BITS - 1 - bit_idx];
		return b;
	endfunction

	// apply one accepted command to the predicted state, give its frame byte if any
	function automatic void encode_command(input cmd_beat_t b, output logic has_byte,
		output frame_beat_t r);
		int unsigned npix;
		int unsigned len;
		int unsigned pos;
		has_byte = 1'b0;
		r = '0;
		case (b.kind)
			KIND_SET: begin
				n_sets++;
				if (b.pixel < pixels_in_use()) begin
					if (b.alpha == ALPHA_FULL)
						color_mem[b.channel][b.pixel] = b.color;
					else
						color_mem[b.channel][b.pixel] =
							blend_color(color_mem[b.channel][b.pixel], b.color, b.alpha);
				end
			end
			KIND_CLEAR: begin
				n_clears++;
				clear_colors();
			end
			KIND_EMIT: begin
				n_emits++;
				npix = pixels_in_use();
				len = LEAD_ZERO_BYTES + npix * BYTES_PER_PIXEL + TRAIL_ZERO_BYTES;
				has_byte = 1'b1;
				if (len == 0) begin
					frame_pos = 0;
					r.last = 1'b1;
				end else begin
					// restart when the frame shrank under the position
					pos = (frame_pos >= len) ? 0 : frame_pos;
					r.tx_byte = bitplane_byte(pos, npix);
					r.last = (pos + 1 >= len);
					frame_pos = r.last ? 0 : (pos + 1) & 32'hffff;
				end
			end
			default: begin
				n_spare++;
			end
		endcase
	endfunction

	// predict an accepted beat and queue its frame byte
	function automatic void log_accepted(input cmd_beat_t b, input logic typed,
		input frame_beat_t typed_byte);
		logic        has_byte;
		frame_beat_t r;
		encode_command(b, has_byte, r);
		if (has_byte)
			pending_frame_bytes.push_back(typed ? typed_byte : r);
	endfunction

	// drive one command beat and wait until it is taken
	task automatic send_beat(input cmd_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.kind    <= b.kind;
		cmd_ch.channel <= b.channel;
		cmd_ch.pixel   <= b.pixel;
		cmd_ch.color   <= b.color;
		cmd_ch.alpha   <= b.alpha;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	task automatic write_pixel_count(input logic [CNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pixel_count_reg = v;
		n_settings++;
	endtask

	// hold the command side low until every queued frame byte has come back
	task automatic wait_frame_drain();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_frame_bytes.size() != 0);
	endtask

	task automatic set_idle_mode(input idle_mode_t m);
		case (m)
			IDLE_SEND: begin
				send_idle_pct  = 67;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 67;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 6;
				recv_stall_pct = 6;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// random command, mostly set and emit, set pixels mostly inside the frame
	function automatic cmd_beat_t random_command();
		cmd_beat_t   b;
		int unsigned sel;
		int unsigned in_use;
		in_use = pixels_in_use();
		sel = $urandom_range(99);
		b.channel = CH_FIELD_W'($urandom_range(CHANNELS - 1));
		b.color = COLOR_BITS'($urandom);
		if (in_use > 0 && $urandom_range(99) < 80)
			b.pixel = PIX_W'($urandom_range(in_use - 1));
		else
			b.pixel = PIX_W'($urandom_range(MAX_PIXELS - 1));
		case ($urandom_range(9))
			0, 1, 2: b.alpha = ALPHA_FULL;
			3:       b.alpha = '0;
			default: b.alpha = ALPHA_W'($urandom_range(255));
		endcase
		if (sel < 50)
			b.kind = KIND_EMIT;
		else if (sel < 92)
			b.kind = KIND_SET;
		else if (sel < 95)
			b.kind = KIND_CLEAR;
		else
			b.kind = KIND_SPARE;
		return b;
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		frame_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// frame beat checker
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (pending_frame_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected frame beat, expected none, got byte %02h last %0b",
					$time, frame_ch.tx_byte, frame_ch.last);
			end else begin
				want = pending_frame_bytes.pop_front();
				bytes_checked++;
				if (frame_ch.last === 1'b1)
					lasts_seen++;
				if (frame_ch.tx_byte !== want.tx_byte) begin
					errors++;
					$display("%0t: tx_byte mismatch, expected %02h, got %02h",
						$time, want.tx_byte, frame_ch.tx_byte);
				end
				if (frame_ch.last !== want.last) begin
					errors++;
					$display("%0t: last mismatch, expected %0b, got %0b",
						$time, want.last, frame_ch.last);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [CNT_W-1:0] phase_counts [PHASES];
		cmd_beat_t        b;
		frame_beat_t      typed_byte;
		int               done;
		logic             paused;

		cmd_ch.valid   <= 1'b0;
		cmd_ch.kind    <= KIND_SET;
		cmd_ch.channel <= '0;
		cmd_ch.pixel   <= '0;
		cmd_ch.color   <= '0;
		cmd_ch.alpha   <= '0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		arst_n         <= 1'b0;

		errors = 0;
		n_sets = 0;
		n_clears = 0;
		n_emits = 0;
		n_spare = 0;
		n_settings = 0;
		bytes_checked = 0;
		lasts_seen = 0;
		paused = 1'b0;
		clear_colors();
		frame_pos = 0;
		pixel_count_reg = '0;
		set_idle_mode(IDLE_NONE);

		// one pixel per channel: the frame is 80 bytes, bytes 0..3 are lead zeros
		dir_rows = '{
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd0, 9'd0,   24'hffffff, 8'd255, 1'b0, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd7, 9'd0,   24'h800001, 8'd255, 1'b0, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd3, 9'd0,   24'h123456, 8'd0,   1'b0, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd3, 9'd0,   24'hffffff, 8'd128, 1'b0, PULSE_LOW,  1'b0},
			// pixels past the count in use are dropped
			'{KIND_SET,   3'd5, 9'd1,   24'habcdef, 8'd255, 1'b0, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd1, 9'd511, 24'hffffff, 8'd255, 1'b0, PULSE_LOW,  1'b0},
			// unused kind does nothing
			'{KIND_SPARE, 3'd7, 9'd511, 24'hffffff, 8'd255, 1'b0, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_HIGH, 1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b0, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			// blend with the smallest and largest partial weights
			'{KIND_SET,   3'd0, 9'd0,   24'h000000, 8'd1,   1'b0, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd7, 9'd0,   24'hffffff, 8'd254, 1'b0, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_HIGH, 1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b0, PULSE_LOW,  1'b0},
			'{KIND_CLEAR, 3'd0, 9'd0,   24'h000000, 8'd0,   1'b0, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_HIGH, 1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_SET,   3'd6, 9'd0,   24'hffffff, 8'd255, 1'b0, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_LOW,  1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b1, PULSE_HIGH, 1'b0},
			'{KIND_EMIT,  3'd0, 9'd0,   24'h000000, 8'd0,   1'b0, PULSE_LOW,  1'b0}
		};
		phase_counts = '{10'd2, 10'd3, 10'd512, 10'd1, 10'd0, 10'd1023, 10'd2, 10'd1};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_pixel_count(10'd1);

		// directed rows
		for (int i = 0; i < DIR_N; i++) begin
			b = '{dir_rows[i].kind, dir_rows[i].channel, dir_rows[i].pixel,
				dir_rows[i].color, dir_rows[i].alpha};
			typed_byte = '{dir_rows[i].tx_byte, dir_rows[i].last};
			send_beat(b);
			log_accepted(b, dir_rows[i].typed, typed_byte);
		end

		// random phases, each under a new pixel count and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			wait_frame_drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_pixel_count(phase_counts[p]);
			set_idle_mode(idle_mode_t'(p % 4));
			done = 0;
			while (done < RAND_PER_PHASE) begin
				b = random_command();
				send_beat(b);
				log_accepted(b, 1'b0, '0);
				if (b.kind == KIND_EMIT || b.kind == KIND_CLEAR ||
					(b.kind == KIND_SET && b.pixel < pixels_in_use()))
					done++;
				// hold off once mid-phase until the output side has caught up
				if (p == 1 && done == 40 && !paused) begin
					paused = 1'b1;
					wait_frame_drain();
				end
			end
		end

		wait_frame_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d sets, %0d clears, %0d emits, %0d unused kinds over %0d pixel counts",
			n_sets, n_clears, n_emits, n_spare, n_settings);
		$display("checked %0d frame bytes, %0d frame ends, %0d mismatches",
			bytes_checked, lasts_seen, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
